@@ rtl/core/modexp_pkg.sv @@
package modexp_pkg;

   // port width of every payload field, the modulus input included
   localparam int DATA_W = 64;

   // default operand width inside the datapath
   localparam int WIDTH_DEFAULT = 64;

   // modulus after reset
   localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(2);

endpackage

@@ rtl/core/modular_exponentiation.sv @@
// modular exponentiation: rsp_power_result = req_base_value ** req_exponent_value mod modulus
//
// csr channel: csr_modulus is written when csr_valid and csr_ready are both high;
// csr_ready is high only while the block is idle and no request is offered on start.
// only the low WIDTH bits are kept.
// request channel: a request is taken at the clock edge where start is high and busy
// is low. busy stays high from the edge after that until the result is produced.
// response channel: rsp_valid is high for exactly one cycle with rsp_power_result;
// the receiver cannot stall, so the result must be taken in that cycle.
// a new request may be issued in the cycle where rsp_valid is high.
//
// one shared shift-and-add modular multiplier handles one multiplier bit per cycle.
// the base is first reduced by the modulus (one product), then each exponent bit up
// to the highest set one passes through the test and shift states and costs one
// squaring (none after the highest), plus one more product for each set bit.
// a modulus below two is answered with 0 straight from idle; busy does not rise.
// a new request is taken only after the last one has been answered. reset (synchronous,
// active high) returns the sequencer to idle, drops rsp_valid and sets the modulus
// back to 2.
module modular_exponentiation #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [modexp_pkg::DATA_W-1:0] req_base_value,
   input  logic [modexp_pkg::DATA_W-1:0] req_exponent_value,
   output logic                          rsp_valid,
   output logic [modexp_pkg::DATA_W-1:0] rsp_power_result,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [modexp_pkg::DATA_W-1:0] csr_modulus
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;  // one multiplier bit per cycle
   localparam logic [2:0] ST_TEST  = 3'd2;  // check exponent, maybe multiply accumulator
   localparam logic [2:0] ST_SHIFT = 3'd3;  // halve exponent, maybe square power

   // where a finished product goes
   localparam logic DST_POW = 1'b0;
   localparam logic DST_ACC = 1'b1;

   logic [2:0]       state_ff, state_in;
   logic [WIDTH-1:0] mod_ff, mod_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] pow_ff, pow_in;
   logic [WIDTH-1:0] opa_ff, opa_in;      // addend operand, below the modulus
   logic [WIDTH-1:0] opb_ff, opb_in;      // multiplier, scanned from its top bit
   logic [WIDTH-1:0] part_ff, part_in;    // running partial product
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             dst_ff, dst_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // shared step: part = (2*part + bit*opa) mod modulus
   logic [WIDTH:0]   dbl, dbl_red, sum;
   logic [WIDTH-1:0] step_res;

   always_comb begin
      dbl      = {part_ff, 1'b0};
      dbl_red  = (dbl >= {1'b0, mod_ff}) ? dbl - {1'b0, mod_ff} : dbl;
      sum      = dbl_red + (opb_ff[WIDTH-1] ? {1'b0, opa_ff} : '0);
      step_res = (sum >= {1'b0, mod_ff}) ? WIDTH'(sum - {1'b0, mod_ff}) : WIDTH'(sum);
   end

   logic [WIDTH-1:0] exp_half;
   assign exp_half = exp_ff >> 1;

   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      pow_in       = pow_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      part_in      = part_ff;
      cnt_in       = cnt_ff;
      dst_in       = dst_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               mod_in = csr_modulus[WIDTH-1:0];
            end
            if (start) begin
               if (mod_ff[WIDTH-1:1] == '0) begin
                  // modulus of 0 or 1 acts as 1
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  // reduce the base: 1 * base mod m
                  exp_in   = req_exponent_value[WIDTH-1:0];
                  acc_in   = WIDTH'(1);
                  opa_in   = WIDTH'(1);
                  opb_in   = req_base_value[WIDTH-1:0];
                  part_in  = '0;
                  cnt_in   = '0;
                  dst_in   = DST_POW;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            part_in = step_res;
            opb_in  = opb_ff << 1;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               if (dst_ff == DST_ACC) begin
                  acc_in   = step_res;
                  state_in = ST_SHIFT;
               end else begin
                  pow_in   = step_res;
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            if (exp_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end else if (exp_ff[0]) begin
               opa_in   = acc_ff;
               opb_in   = pow_ff;
               part_in  = '0;
               cnt_in   = '0;
               dst_in   = DST_ACC;
               state_in = ST_MUL;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            exp_in = exp_half;
            if (exp_half == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end else begin
               // square the running power
               opa_in   = pow_ff;
               opb_in   = pow_ff;
               part_in  = '0;
               cnt_in   = '0;
               dst_in   = DST_POW;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_ff       <= MODULUS_RESET[WIDTH-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      pow_ff      <= pow_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      part_ff     <= part_in;
      cnt_ff      <= cnt_in;
      dst_ff      <= dst_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   // no modulus change while a request is being taken
   assign csr_ready        = (state_ff == ST_IDLE) && !start;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = DATA_W'(rsp_data_ff);

endmodule
